/* sv/mmc_pkg.sv */
package mmc_pkg;

    localparam int SAMPLE_BITS     = 16;
    localparam int SCALE_FRAC_BITS = 14;
    localparam int COEF_FRAC_BITS  = 12;
    localparam int INIT_RANGE      = 100;

    localparam int SCALE_BITS = 8 + SCALE_FRAC_BITS;
    localparam int RANGE_BITS = SAMPLE_BITS + 1;
    localparam int SUM_BITS   = RANGE_BITS + 2;
    localparam int NUM_BITS   = SUM_BITS + SCALE_FRAC_BITS;
    localparam int DVS_BITS   = RANGE_BITS + 2;
    localparam int DIFF_BITS  = SAMPLE_BITS + 1;
    localparam int MULB_BITS  = SCALE_BITS + 1;
    localparam int PROD_BITS  = DIFF_BITS + MULB_BITS;
    localparam int ACC_BITS   = PROD_BITS + 2;
    localparam int COEF_BITS  = 16;
    localparam int CNT_BITS   = $clog2(NUM_BITS);

    localparam logic [SCALE_BITS-1:0] SCALE_ONE = SCALE_BITS'(1) << SCALE_FRAC_BITS;
    localparam logic [SCALE_BITS-1:0] SCALE_MAX = {SCALE_BITS{1'b1}};

    localparam logic [2:0] REG_USE_STORED = 3'd0;
    localparam logic [2:0] REG_OFFSET_X   = 3'd1;
    localparam logic [2:0] REG_OFFSET_Y   = 3'd2;
    localparam logic [2:0] REG_OFFSET_Z   = 3'd3;
    localparam logic [2:0] REG_COEF_X     = 3'd4;
    localparam logic [2:0] REG_COEF_Y     = 3'd5;
    localparam logic [2:0] REG_COEF_Z     = 3'd6;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPD,
        ST_LOAD,
        ST_DIV,
        ST_DFIN,
        ST_MUL,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic       upd;
        logic       load;
        logic       div;
        logic       dfin;
        logic       mul;
        logic       stored;
        logic [1:0] step;
    } lane_ctl_t;

endpackage

/* sv/magnetometer_minmax_calibrator_unit.sv */
// Three-axis magnetometer calibrator with min/max tracking.
// s_ channel: one sample per request, tdata = {sensor_z, sensor_y, sensor_x}.
// The sample is remapped for side mounting (y <- sensor z, z <- -sensor y).
// m_ channel: one result per sample, tdata = {cal_z, cal_y, cal_x},
// tuser = {saturated, range_changed}.
// cfg_ channel: register writes (index, data), always ready; write only when idle.
// Three identical lanes, one per axis, track min/max, center and scale, and
// each has its own restoring divider and multiply-accumulate unit.
// When a range widens, a restoring divider runs 33 iterations, one quotient
// bit a cycle, to find the new scale. Stored mode forms the three matrix
// products per lane one after another on the lane's own multiplier.
// One sample is in flight at a time; s_tready is high only while idle.
// A finished result sits in the output register; the next sample is taken
// while it waits, and a stalled receiver holds up only the following result.
// Reset: min/max = -/+100, centers 0, scales 1.0, identity matrix, self mode.
module magnetometer_minmax_calibrator_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // sensor_x, sensor_y, sensor_z
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // cal_x, cal_y, cal_z
    output logic [1:0]  m_tuser,   // range_changed, saturated
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [47:0] cfg_data
);
    localparam int SB = mmc_pkg::SAMPLE_BITS;

    mmc_pkg::state_t state_reg, state_next;
    logic [mmc_pkg::CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [1:0] step_reg, step_next;

    logic signed [SB-1:0] m_reg [3];
    logic clip_reg;
    logic stored_reg;
    logic signed [SB-1:0] off_reg [3];
    logic [47:0] coef_reg [3];

    logic m_tvalid_reg;
    logic [47:0] m_tdata_reg;
    logic [1:0] m_tuser_reg;

    mmc_pkg::lane_ctl_t ctl;
    logic load_out;
    logic [mmc_pkg::RANGE_BITS-1:0] range_w [3];
    logic changed_w [3];
    logic signed [SB-1:0] res_w [3];
    logic clip_w [3];
    logic [mmc_pkg::SUM_BITS-1:0] range_sum;
    logic signed [mmc_pkg::DIFF_BITS-1:0] c_sel;
    logic signed [SB-1:0] neg_y;
    logic any_changed;

    assign s_tready  = (state_reg == mmc_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;

    assign range_sum = mmc_pkg::SUM_BITS'(range_w[0]) + mmc_pkg::SUM_BITS'(range_w[1])
                       + mmc_pkg::SUM_BITS'(range_w[2]);
    assign c_sel = mmc_pkg::DIFF_BITS'(m_reg[step_reg]) - mmc_pkg::DIFF_BITS'(off_reg[step_reg]);
    assign any_changed = changed_w[0] | changed_w[1] | changed_w[2];
    assign neg_y = -$signed(s_tdata[31:16]);

    for (genvar j = 0; j < 3; j++) begin : g_lane
        mmc_lane u_lane (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctl       (ctl),
            .sample    (m_reg[j]),
            .range_sum (range_sum),
            .c_sel     (c_sel),
            .coef_sel  (coef_reg[j][16*step_reg +: 16]),
            .range     (range_w[j]),
            .changed   (changed_w[j]),
            .res       (res_w[j]),
            .clip      (clip_w[j])
        );
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        step_next  = step_reg;
        ctl        = '0;
        ctl.stored = stored_reg;
        ctl.step   = step_reg;
        load_out   = 1'b0;
        unique case (state_reg)
            mmc_pkg::ST_IDLE: begin
                if (s_tvalid) state_next = mmc_pkg::ST_UPD;
            end
            mmc_pkg::ST_UPD: begin
                ctl.upd    = 1'b1;
                state_next = mmc_pkg::ST_LOAD;
            end
            mmc_pkg::ST_LOAD: begin
                step_next = '0;
                if (any_changed) begin
                    ctl.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = mmc_pkg::ST_DIV;
                end else begin
                    state_next = mmc_pkg::ST_MUL;
                end
            end
            mmc_pkg::ST_DIV: begin
                ctl.div  = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == mmc_pkg::CNT_BITS'(mmc_pkg::NUM_BITS - 1))
                    state_next = mmc_pkg::ST_DFIN;
            end
            mmc_pkg::ST_DFIN: begin
                ctl.dfin   = 1'b1;
                state_next = mmc_pkg::ST_MUL;
            end
            mmc_pkg::ST_MUL: begin
                ctl.mul = 1'b1;
                if (!stored_reg || step_reg == 2'd2) begin
                    state_next = mmc_pkg::ST_OUT;
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
            mmc_pkg::ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    load_out   = 1'b1;
                    state_next = mmc_pkg::ST_IDLE;
                end
            end
            default: state_next = mmc_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= mmc_pkg::ST_IDLE;
            cnt_reg      <= '0;
            step_reg     <= '0;
            m_tvalid_reg <= 1'b0;
            stored_reg   <= 1'b0;
            off_reg[0]   <= '0;
            off_reg[1]   <= '0;
            off_reg[2]   <= '0;
            coef_reg[0]  <= 48'(1) << mmc_pkg::COEF_FRAC_BITS;
            coef_reg[1]  <= 48'(1) << (mmc_pkg::COEF_FRAC_BITS + 16);
            coef_reg[2]  <= 48'(1) << (mmc_pkg::COEF_FRAC_BITS + 32);
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            step_reg  <= step_next;
            if (load_out)                   m_tvalid_reg <= 1'b1;
            else if (m_tready)              m_tvalid_reg <= 1'b0;
            if (cfg_valid) begin
                unique case (cfg_index)
                    mmc_pkg::REG_USE_STORED: stored_reg  <= cfg_data[0];
                    mmc_pkg::REG_OFFSET_X:   off_reg[0]  <= cfg_data[15:0];
                    mmc_pkg::REG_OFFSET_Y:   off_reg[1]  <= cfg_data[15:0];
                    mmc_pkg::REG_OFFSET_Z:   off_reg[2]  <= cfg_data[15:0];
                    mmc_pkg::REG_COEF_X:     coef_reg[0] <= cfg_data;
                    mmc_pkg::REG_COEF_Y:     coef_reg[1] <= cfg_data;
                    mmc_pkg::REG_COEF_Z:     coef_reg[2] <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            m_reg[0] <= s_tdata[15:0];
            m_reg[1] <= s_tdata[47:32];
            // negating the most negative y clips to the largest positive value
            if (s_tdata[31:16] == {1'b1, {(SB-1){1'b0}}}) begin
                m_reg[2] <= {1'b0, {(SB-1){1'b1}}};
                clip_reg <= 1'b1;
            end else begin
                m_reg[2] <= neg_y;
                clip_reg <= 1'b0;
            end
        end
        if (load_out) begin
            m_tdata_reg <= {res_w[2], res_w[1], res_w[0]};
            m_tuser_reg <= {clip_reg | clip_w[0] | clip_w[1] | clip_w[2], any_changed};
        end
    end

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second sample taken while one is in flight");

    a_out_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == mmc_pkg::ST_OUT && (!m_tvalid_reg || m_tready)) |=> m_tvalid)
        else $error("finished result not presented");

    a_out_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == mmc_pkg::ST_OUT))
        else $error("result raised outside output state");

    a_div_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == mmc_pkg::ST_DFIN) |-> $past(state_reg == mmc_pkg::ST_DIV))
        else $error("divider finished without iterating");

endmodule

/* sv/mmc_lane.sv */
module mmc_lane (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  mmc_pkg::lane_ctl_t                      ctl,
    input  logic signed [mmc_pkg::SAMPLE_BITS-1:0]  sample,
    input  logic [mmc_pkg::SUM_BITS-1:0]            range_sum,
    input  logic signed [mmc_pkg::DIFF_BITS-1:0]    c_sel,
    input  logic signed [mmc_pkg::COEF_BITS-1:0]    coef_sel,
    output logic [mmc_pkg::RANGE_BITS-1:0]          range,
    output logic                                    changed,
    output logic signed [mmc_pkg::SAMPLE_BITS-1:0]  res,
    output logic                                    clip
);
    localparam int SB = mmc_pkg::SAMPLE_BITS;

    logic signed [SB-1:0] min_reg, max_reg, center_reg;
    logic [mmc_pkg::SCALE_BITS-1:0] scale_reg;
    logic changed_reg;
    logic [mmc_pkg::NUM_BITS-1:0] num_reg, quo_reg;
    logic [mmc_pkg::DVS_BITS:0] rem_reg;
    logic [mmc_pkg::DVS_BITS-1:0] dvs_reg;
    logic signed [mmc_pkg::ACC_BITS-1:0] acc_reg;

    logic signed [SB:0] mid;
    logic [mmc_pkg::DVS_BITS:0] trial;
    logic signed [mmc_pkg::DIFF_BITS-1:0] mul_a;
    logic signed [mmc_pkg::MULB_BITS-1:0] mul_b;
    logic signed [mmc_pkg::PROD_BITS-1:0] prod;
    logic signed [mmc_pkg::ACC_BITS-1:0] biased, shifted;
    logic signed [mmc_pkg::ACC_BITS-1:0] hi_lim, lo_lim;

    assign range   = {max_reg[SB-1], max_reg} - {min_reg[SB-1], min_reg};
    assign changed = changed_reg;

    always_comb begin
        mid   = (SB+1)'(max_reg) + (SB+1)'(min_reg);
        trial = {rem_reg[mmc_pkg::DVS_BITS-1:0], num_reg[mmc_pkg::NUM_BITS-1]};
        if (ctl.stored) begin
            mul_a = c_sel;
            mul_b = mmc_pkg::MULB_BITS'(coef_sel);
        end else begin
            mul_a = mmc_pkg::DIFF_BITS'(sample) - mmc_pkg::DIFF_BITS'(center_reg);
            mul_b = $signed({1'b0, scale_reg});
        end
        prod = mul_a * mul_b;
        // truncate toward zero: bias negatives before the arithmetic shift
        if (ctl.stored) begin
            biased  = acc_reg + (acc_reg[mmc_pkg::ACC_BITS-1] ?
                      mmc_pkg::ACC_BITS'((1 << mmc_pkg::COEF_FRAC_BITS) - 1) : '0);
            shifted = biased >>> mmc_pkg::COEF_FRAC_BITS;
        end else begin
            biased  = acc_reg + (acc_reg[mmc_pkg::ACC_BITS-1] ?
                      mmc_pkg::ACC_BITS'((1 << mmc_pkg::SCALE_FRAC_BITS) - 1) : '0);
            shifted = biased >>> mmc_pkg::SCALE_FRAC_BITS;
        end
        hi_lim = mmc_pkg::ACC_BITS'((1 << (SB-1)) - 1);
        lo_lim = -hi_lim - 1;
        if (shifted > hi_lim) begin
            res  = SB'(hi_lim);
            clip = 1'b1;
        end else if (shifted < lo_lim) begin
            res  = SB'(lo_lim);
            clip = 1'b1;
        end else begin
            res  = SB'(shifted);
            clip = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_reg     <= -SB'(mmc_pkg::INIT_RANGE);
            max_reg     <= SB'(mmc_pkg::INIT_RANGE);
            center_reg  <= '0;
            scale_reg   <= mmc_pkg::SCALE_ONE;
            changed_reg <= 1'b0;
        end else begin
            if (ctl.upd) begin
                changed_reg <= (sample < min_reg) || (sample > max_reg);
                if (sample < min_reg) min_reg <= sample;
                if (sample > max_reg) max_reg <= sample;
            end
            if (ctl.load) begin
                center_reg <= SB'((mid + (SB+1)'(mid[SB])) >>> 1);
            end
            if (ctl.dfin) begin
                scale_reg <= (quo_reg > mmc_pkg::NUM_BITS'(mmc_pkg::SCALE_MAX)) ?
                             mmc_pkg::SCALE_MAX : quo_reg[mmc_pkg::SCALE_BITS-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            num_reg <= {range_sum, {mmc_pkg::SCALE_FRAC_BITS{1'b0}}};
            rem_reg <= '0;
            quo_reg <= '0;
            dvs_reg <= mmc_pkg::DVS_BITS'({range, 1'b0}) + mmc_pkg::DVS_BITS'(range);
        end else if (ctl.div) begin
            num_reg <= num_reg << 1;
            if (trial >= {1'b0, dvs_reg}) begin
                rem_reg <= trial - {1'b0, dvs_reg};
                quo_reg <= {quo_reg[mmc_pkg::NUM_BITS-2:0], 1'b1};
            end else begin
                rem_reg <= trial;
                quo_reg <= {quo_reg[mmc_pkg::NUM_BITS-2:0], 1'b0};
            end
        end
        if (ctl.mul) begin
            if (ctl.step == 2'd0) acc_reg <= mmc_pkg::ACC_BITS'(prod);
            else                  acc_reg <= acc_reg + mmc_pkg::ACC_BITS'(prod);
        end
    end

endmodule
